// ===== src/cdn_pkg.sv =====
// ----------------------------------------------------------------------------
// Calendar date navigator package
// Shared command codes, the queued command record and the date helpers used
// by the front end and by the execution stage.
// ----------------------------------------------------------------------------
package cdn_pkg;

   localparam logic [3:0] OP_WEEK_UP    = 4'd0;
   localparam logic [3:0] OP_WEEK_DOWN  = 4'd1;
   localparam logic [3:0] OP_DAY_LEFT   = 4'd2;
   localparam logic [3:0] OP_DAY_RIGHT  = 4'd3;
   localparam logic [3:0] OP_PREV_MONTH = 4'd4;
   localparam logic [3:0] OP_NEXT_MONTH = 4'd5;
   localparam logic [3:0] OP_PREV_YEAR  = 4'd6;
   localparam logic [3:0] OP_NEXT_YEAR  = 4'd7;
   localparam logic [3:0] OP_SELECT     = 4'd8;
   localparam logic [3:0] OP_TODAY      = 4'd9;

   localparam logic [13:0] YEAR_MAX    = 14'd9999;
   localparam logic [6:0]  CENT_MAX    = 7'd99;
   localparam logic [6:0]  YY_MAX      = 7'd99;
   localparam logic [3:0]  MONTH_FIRST = 4'd1;
   localparam logic [3:0]  MONTH_FEB   = 4'd2;
   localparam logic [3:0]  MONTH_LAST  = 4'd12;
   localparam logic [4:0]  DAY_FIRST   = 5'd1;
   localparam logic [4:0]  DAYS_LONG   = 5'd31;
   localparam logic [4:0]  DAYS_SHORT  = 5'd30;
   localparam logic [4:0]  DAYS_FEB    = 5'd28;
   localparam logic [4:0]  DAYS_FEB_LP = 5'd29;
   localparam logic [5:0]  WEEK_DAYS   = 6'd7;
   localparam logic [4:0]  WEEK_FLOOR  = 5'd8;

   // floor(y / 100) equals (y * 5243) >> 19 for every y up to 9999.
   localparam logic [26:0] RECIP_100   = 27'd5243;
   localparam int          RECIP_SHIFT = 19;

   localparam logic [6:0]  RESET_CENT  = 7'd20;
   localparam logic [6:0]  RESET_YY    = 7'd0;

   // The year travels as a century and a year within the century.
   typedef struct packed {
      logic       handled;
      logic [3:0] opcode;
      logic [6:0] t_cent;
      logic [6:0] t_yy;
      logic [3:0] t_month;
      logic [4:0] t_day;
   } cmd_type;

   function automatic logic is_leap(input logic [6:0] cent, input logic [6:0] yy);
      return (yy[1:0] == 2'd0) && ((yy != 7'd0) || (cent[1:0] == 2'd0));
   endfunction

   function automatic logic [4:0] month_days(input logic leap, input logic [3:0] month);
      logic [4:0] days;
      case (month)
         4'd2: begin
            days = leap ? DAYS_FEB_LP : DAYS_FEB;
         end
         4'd4, 4'd6, 4'd9, 4'd11: begin
            days = DAYS_SHORT;
         end
         default: begin
            days = DAYS_LONG;
         end
      endcase
      return days;
   endfunction

   function automatic logic [13:0] mul100(input logic [6:0] cent);
      logic [13:0] c;
      c = {7'd0, cent};
      return (c << 6) + (c << 5) + (c << 2);
   endfunction

   function automatic logic [4:0] min_day(input logic [4:0] a, input logic [4:0] b);
      return (a > b) ? b : a;
   endfunction

endpackage

// ===== src/calendar_date_navigator_unit.sv =====
// ----------------------------------------------------------------------------
// Calendar date navigator
// Keeps a current date and applies one navigation command per transaction.
// ----------------------------------------------------------------------------
// Usage:
//   The req_ channel carries one command per transaction: an opcode and the
//   date that the today command loads. The rsp_ channel returns one result
//   per command: handled, date_selected and the date after the command.
//   The csr_ port writes the enable bit; write it only while no command is
//   in flight.
//   A result shows on rsp_tvalid once its command has waited in the queue
//   and has then been written into the output register.
//   Throughput is one command per cycle while rsp_tready stays high; it
//   rests on the combinational date update in the execution stage.
//   When the receiver stalls, the result holds in the output register and
//   the two-entry command queue absorbs further commands; req_tready drops
//   once the queue is full.
//   A synchronous reset sets the date to 1 January 2000, sets the enable
//   bit, and empties the queue and the output register.
// ----------------------------------------------------------------------------
module calendar_date_navigator_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic        csr_wr_data,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // opcode[3:0], today_year[17:4],
                                    // today_month[21:18], today_day[26:22]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata    // handled[0], date_selected[1],
                                    // cur_year[15:2], cur_month[19:16],
                                    // cur_day[24:20]
);
   import cdn_pkg::*;

   logic    push_valid;
   logic    push_ready;
   cmd_type push_cmd;
   logic    pop_valid;
   logic    pop_ready;
   cmd_type pop_cmd;

   cdn_front u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .push_valid  (push_valid),
      .push_ready  (push_ready),
      .push_cmd    (push_cmd)
   );

   cdn_cmd_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cmd   (push_cmd),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_cmd    (pop_cmd)
   );

   cdn_exec u_exec (
      .clock      (clock),
      .reset      (reset),
      .cmd_valid  (pop_valid),
      .cmd_ready  (pop_ready),
      .cmd        (pop_cmd),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

// ===== src/cdn_front.sv =====
// ----------------------------------------------------------------------------
// Calendar date navigator front end
// Holds the enable register, classifies each incoming command and splits the
// today year into century and year-in-century before queuing it.
// ----------------------------------------------------------------------------
module cdn_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_wr_en,
   input  logic             csr_wr_data,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [31:0]      req_tdata,   // opcode[3:0], today_year[17:4],
                                         // today_month[21:18], today_day[26:22]
   output logic             push_valid,
   input  logic             push_ready,
   output cdn_pkg::cmd_type push_cmd
);
   import cdn_pkg::*;

   logic        enabled_ff;
   logic        enabled_in;
   logic [3:0]  opcode;
   logic [13:0] t_year;
   logic [3:0]  t_month;
   logic [4:0]  t_day;
   logic [13:0] year_sat;
   logic [26:0] quot_prod;
   logic [6:0]  cent;
   logic [13:0] rem_year;

   assign opcode  = req_tdata[3:0];
   assign t_year  = req_tdata[17:4];
   assign t_month = req_tdata[21:18];
   assign t_day   = req_tdata[26:22];

   assign enabled_in = csr_wr_en ? csr_wr_data : enabled_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         enabled_ff <= 1'b1;
      end else begin
         enabled_ff <= enabled_in;
      end
   end

   assign year_sat  = (t_year > YEAR_MAX) ? YEAR_MAX : t_year;
   assign quot_prod = {13'd0, year_sat} * RECIP_100;
   assign cent      = quot_prod[RECIP_SHIFT +: 7];
   assign rem_year  = year_sat - mul100(cent);

   always_comb begin
      push_cmd.handled = enabled_ff && (opcode <= OP_TODAY);
      push_cmd.opcode  = opcode;
      push_cmd.t_cent  = cent;
      push_cmd.t_yy    = rem_year[6:0];
      if (t_month < MONTH_FIRST) begin
         push_cmd.t_month = MONTH_FIRST;
      end else if (t_month > MONTH_LAST) begin
         push_cmd.t_month = MONTH_LAST;
      end else begin
         push_cmd.t_month = t_month;
      end
      push_cmd.t_day = (t_day < DAY_FIRST) ? DAY_FIRST : t_day;
   end

   assign push_valid = req_tvalid;
   assign req_tready = push_ready;

endmodule

// ===== src/cdn_cmd_fifo.sv =====
// ----------------------------------------------------------------------------
// Calendar date navigator command queue
// Two-entry queue that decouples the front end from the execution stage.
// ----------------------------------------------------------------------------
module cdn_cmd_fifo (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  cdn_pkg::cmd_type push_cmd,
   output logic             pop_valid,
   input  logic             pop_ready,
   output cdn_pkg::cmd_type pop_cmd
);
   import cdn_pkg::*;

   cmd_type    mem_ff [2];
   logic       wr_ptr_ff;
   logic       wr_ptr_in;
   logic       rd_ptr_ff;
   logic       rd_ptr_in;
   logic [1:0] count_ff;
   logic [1:0] count_in;
   logic       do_push;
   logic       do_pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;
   assign pop_cmd    = mem_ff[rd_ptr_ff];

   assign wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
   assign rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
   assign count_in  = count_ff + {1'b0, do_push} - {1'b0, do_pop};

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// ===== src/cdn_exec.sv =====
// ----------------------------------------------------------------------------
// Calendar date navigator execution stage
// Holds the current date and applies one queued command per cycle while the
// receiver keeps up, keeping each result in an output register until taken.
// ----------------------------------------------------------------------------
module cdn_exec (
   input  logic             clock,
   input  logic             reset,
   input  logic             cmd_valid,
   output logic             cmd_ready,
   input  cdn_pkg::cmd_type cmd,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [31:0]      rsp_tdata    // handled[0], date_selected[1],
                                         // cur_year[15:2], cur_month[19:16],
                                         // cur_day[24:20]
);
   import cdn_pkg::*;

   logic [6:0]  cent_ff, cent_in;
   logic [6:0]  yy_ff, yy_in;
   logic [3:0]  month_ff, month_in;
   logic [4:0]  day_ff, day_in;
   logic        sel_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic        rsp_handled_ff;
   logic        rsp_sel_ff;
   logic [13:0] rsp_year_ff;
   logic [3:0]  rsp_month_ff;
   logic [4:0]  rsp_day_ff;
   logic        pop;

   assign cmd_ready    = !rsp_valid_ff || rsp_tready;
   assign pop          = cmd_valid && cmd_ready;
   assign rsp_valid_in = pop ? 1'b1 : (rsp_valid_ff && !rsp_tready);

   always_comb begin
      logic       lp_cur, lp_prev, lp_next, lp_today;
      logic [4:0] dim, dim_dec, dim_inc;
      logic [3:0] m_dec, m_inc;
      logic [6:0] prev_cent, prev_yy, next_cent, next_yy;
      logic       at_min, at_max;
      logic [5:0] day_plus;

      lp_cur   = is_leap(cent_ff, yy_ff);
      dim      = month_days(lp_cur, month_ff);
      m_dec    = month_ff - 4'd1;
      m_inc    = month_ff + 4'd1;
      dim_dec  = month_days(lp_cur, m_dec);
      dim_inc  = month_days(lp_cur, m_inc);
      at_min   = (cent_ff == 7'd0) && (yy_ff == 7'd0);
      at_max   = (cent_ff == CENT_MAX) && (yy_ff == YY_MAX);
      if (yy_ff != 7'd0) begin
         prev_cent = cent_ff;
         prev_yy   = yy_ff - 7'd1;
      end else begin
         prev_cent = cent_ff - 7'd1;
         prev_yy   = YY_MAX;
      end
      if (yy_ff != YY_MAX) begin
         next_cent = cent_ff;
         next_yy   = yy_ff + 7'd1;
      end else begin
         next_cent = cent_ff + 7'd1;
         next_yy   = 7'd0;
      end
      lp_prev  = is_leap(prev_cent, prev_yy);
      lp_next  = is_leap(next_cent, next_yy);
      lp_today = is_leap(cmd.t_cent, cmd.t_yy);
      day_plus = {1'b0, day_ff} + WEEK_DAYS;

      cent_in  = cent_ff;
      yy_in    = yy_ff;
      month_in = month_ff;
      day_in   = day_ff;
      sel_in   = 1'b0;

      if (cmd.handled) begin
         case (cmd.opcode)
            OP_WEEK_UP: begin
               day_in = (day_ff > WEEK_FLOOR) ? (day_ff - WEEK_DAYS[4:0]) : DAY_FIRST;
            end
            OP_WEEK_DOWN: begin
               day_in = (day_plus > {1'b0, dim}) ? dim : day_plus[4:0];
            end
            OP_DAY_LEFT: begin
               if (day_ff > DAY_FIRST) begin
                  day_in = day_ff - 5'd1;
               end else if (month_ff > MONTH_FIRST) begin
                  month_in = m_dec;
                  day_in   = dim_dec;
               end else if (!at_min) begin
                  cent_in  = prev_cent;
                  yy_in    = prev_yy;
                  month_in = MONTH_LAST;
                  day_in   = DAYS_LONG;
               end
            end
            OP_DAY_RIGHT: begin
               if (day_ff < dim) begin
                  day_in = day_ff + 5'd1;
               end else if (month_ff < MONTH_LAST) begin
                  month_in = m_inc;
                  day_in   = DAY_FIRST;
               end else if (!at_max) begin
                  cent_in  = next_cent;
                  yy_in    = next_yy;
                  month_in = MONTH_FIRST;
                  day_in   = DAY_FIRST;
               end
            end
            OP_PREV_MONTH: begin
               // Wrapping into December keeps the day, since December has 31.
               if (month_ff > MONTH_FIRST) begin
                  month_in = m_dec;
                  day_in   = min_day(day_ff, dim_dec);
               end else if (!at_min) begin
                  cent_in  = prev_cent;
                  yy_in    = prev_yy;
                  month_in = MONTH_LAST;
               end
            end
            OP_NEXT_MONTH: begin
               if (month_ff < MONTH_LAST) begin
                  month_in = m_inc;
                  day_in   = min_day(day_ff, dim_inc);
               end else if (!at_max) begin
                  cent_in  = next_cent;
                  yy_in    = next_yy;
                  month_in = MONTH_FIRST;
               end
            end
            OP_PREV_YEAR: begin
               if (!at_min) begin
                  cent_in = prev_cent;
                  yy_in   = prev_yy;
                  if (month_ff == MONTH_FEB) begin
                     day_in = min_day(day_ff, month_days(lp_prev, MONTH_FEB));
                  end
               end
            end
            OP_NEXT_YEAR: begin
               if (!at_max) begin
                  cent_in = next_cent;
                  yy_in   = next_yy;
                  if (month_ff == MONTH_FEB) begin
                     day_in = min_day(day_ff, month_days(lp_next, MONTH_FEB));
                  end
               end
            end
            OP_SELECT: begin
               sel_in = 1'b1;
            end
            OP_TODAY: begin
               cent_in  = cmd.t_cent;
               yy_in    = cmd.t_yy;
               month_in = cmd.t_month;
               day_in   = min_day(cmd.t_day, month_days(lp_today, cmd.t_month));
            end
            default: begin
               sel_in = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cent_ff      <= RESET_CENT;
         yy_ff        <= RESET_YY;
         month_ff     <= MONTH_FIRST;
         day_ff       <= DAY_FIRST;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (pop) begin
            cent_ff  <= cent_in;
            yy_ff    <= yy_in;
            month_ff <= month_in;
            day_ff   <= day_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_handled_ff <= cmd.handled;
         rsp_sel_ff     <= sel_in;
         rsp_year_ff    <= mul100(cent_in) + {7'd0, yy_in};
         rsp_month_ff   <= month_in;
         rsp_day_ff     <= day_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_day_ff, rsp_month_ff, rsp_year_ff,
                        rsp_sel_ff, rsp_handled_ff};

endmodule

// ===== src/cdn_checker.sv =====
// ----------------------------------------------------------------------------
// Calendar date navigator checker
// Port-level assertions on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module cdn_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata
);

   // No result may be pending right after reset.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result pending after reset");

   // A stalled result keeps its contents.
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   // A select pulse only comes with a handled command.
   a_sel_handled: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[1] |-> rsp_tdata[0])
      else $error("date_selected without handled");

   // Month stays in 1..12, day is nonzero, year is at most 9999.
   a_month_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[19:16] != 4'd0) && (rsp_tdata[19:16] <= 4'd12))
      else $error("month out of range");

   a_date_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[24:20] != 5'd0) && (rsp_tdata[15:2] <= 14'd9999))
      else $error("day or year out of range");

endmodule

bind calendar_date_navigator_unit cdn_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// ===== test/testbench.sv =====
// ----------------------------------------------------------------------------
// Calendar date navigator testbench
// Drives navigation commands into calendar_date_navigator_unit through the
// req_ stream and checks every rsp_ transaction against a date model kept in
// the testbench. A short scripted sequence covers the year ends, leap rules
// and the today saturation. Random commands follow in phases with the enable
// bit toggled between them. Random gaps on both sides and one long receiver
// stall exercise the command queue.
// ----------------------------------------------------------------------------
module testbench;
   import cdn_pkg::*;

   localparam logic [3:0] OP_OTHER    = 4'd10;
   localparam logic [3:0] OP_TOP_CODE = 4'd15;
   localparam int         CYCLE_LIMIT = 400000;
   localparam int         NUM_PHASES  = 6;
   localparam int         SCRIPT_ROWS = 26;

   typedef struct packed {
      logic        handled;
      logic        selected;
      logic [13:0] year;
      logic [3:0]  month;
      logic [4:0]  day;
   } date_result_type;

   typedef struct packed {
      logic [3:0]      op;
      logic [13:0]     today_year;
      logic [3:0]      today_month;
      logic [4:0]      today_day;
      logic            typed;
      date_result_type result;
   } script_row_type;

   logic        clock;
   logic        reset       = 1'b1;
   logic        csr_wr_en   = 1'b0;
   logic        csr_wr_data = 1'b0;
   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata   = '0;
   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b0;
   logic [31:0] rsp_tdata;

   // Date model state.
   int nav_year    = 2000;
   int nav_month   = 1;
   int nav_day     = 1;
   bit nav_enabled = 1'b1;

   date_result_type pending_dates [$];
   int              mismatch_count = 0;
   int              result_count   = 0;
   int              cycle_count    = 0;
   bit              steady_run     = 1'b0;
   bit              long_hold_done = 1'b0;
   int              stall_left     = 0;

   int phase_items  [NUM_PHASES] = '{150, 40, 200, 20, 200, 90};
   bit phase_enable [NUM_PHASES] = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1};

   script_row_type date_script [SCRIPT_ROWS] = '{
      '{OP_SELECT,     14'd0,     4'd0,  5'd0,  1'b1, '{1'b1, 1'b1, 14'd2000, 4'd1,  5'd1}},
      '{OP_DAY_LEFT,   14'd0,     4'd0,  5'd0,  1'b1, '{1'b1, 1'b0, 14'd1999, 4'd12, 5'd31}},
      '{OP_DAY_RIGHT,  14'd0,     4'd0,  5'd0,  1'b1, '{1'b1, 1'b0, 14'd2000, 4'd1,  5'd1}},
      '{OP_WEEK_UP,    14'd0,     4'd0,  5'd0,  1'b1, '{1'b1, 1'b0, 14'd2000, 4'd1,  5'd1}},
      '{OP_WEEK_DOWN,  14'd0,     4'd0,  5'd0,  1'b1, '{1'b1, 1'b0, 14'd2000, 4'd1,  5'd8}},
      '{OP_TODAY,      14'd0,     4'd1,  5'd1,  1'b1, '{1'b1, 1'b0, 14'd0,    4'd1,  5'd1}},
      '{OP_DAY_LEFT,   14'd0,     4'd0,  5'd0,  1'b1, '{1'b1, 1'b0, 14'd0,    4'd1,  5'd1}},
      '{OP_PREV_MONTH, 14'd0,     4'd0,  5'd0,  1'b1, '{1'b1, 1'b0, 14'd0,    4'd1,  5'd1}},
      '{OP_PREV_YEAR,  14'd0,     4'd0,  5'd0,  1'b1, '{1'b1, 1'b0, 14'd0,    4'd1,  5'd1}},
      '{OP_TODAY,      14'd16383, 4'd15, 5'd31, 1'b1, '{1'b1, 1'b0, 14'd9999, 4'd12, 5'd31}},
      '{OP_DAY_RIGHT,  14'd0,     4'd0,  5'd0,  1'b1, '{1'b1, 1'b0, 14'd9999, 4'd12, 5'd31}},
      '{OP_NEXT_MONTH, 14'd0,     4'd0,  5'd0,  1'b1, '{1'b1, 1'b0, 14'd9999, 4'd12, 5'd31}},
      '{OP_NEXT_YEAR,  14'd0,     4'd0,  5'd0,  1'b1, '{1'b1, 1'b0, 14'd9999, 4'd12, 5'd31}},
      '{OP_TODAY,      14'd2000,  4'd0,  5'd0,  1'b1, '{1'b1, 1'b0, 14'd2000, 4'd1,  5'd1}},
      '{OP_TODAY,      14'd1900,  4'd2,  5'd31, 1'b1, '{1'b1, 1'b0, 14'd1900, 4'd2,  5'd28}},
      '{OP_TODAY,      14'd2000,  4'd2,  5'd31, 1'b1, '{1'b1, 1'b0, 14'd2000, 4'd2,  5'd29}},
      '{OP_PREV_YEAR,  14'd0,     4'd0,  5'd0,  1'b0, '0},
      '{OP_NEXT_YEAR,  14'd0,     4'd0,  5'd0,  1'b0, '0},
      '{OP_WEEK_DOWN,  14'd0,     4'd0,  5'd0,  1'b0, '0},
      '{OP_NEXT_MONTH, 14'd0,     4'd0,  5'd0,  1'b0, '0},
      '{OP_TODAY,      14'd2023,  4'd5,  5'd31, 1'b0, '0},
      '{OP_PREV_MONTH, 14'd0,     4'd0,  5'd0,  1'b0, '0},
      '{OP_WEEK_UP,    14'd0,     4'd0,  5'd0,  1'b0, '0},
      '{OP_DAY_RIGHT,  14'd0,     4'd0,  5'd0,  1'b0, '0},
      '{OP_OTHER,      14'd1234,  4'd6,  5'd15, 1'b0, '0},
      '{OP_TOP_CODE,   14'd8191,  4'd9,  5'd16, 1'b0, '0}
   };

   calendar_date_navigator_unit u_top (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("calendar_date_navigator_unit: mismatch");
         $finish;
      end
   end

   function automatic int month_length(input int y, input int m);
      bit leap_year;
      leap_year = ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
      case (m)
         2: begin
            return leap_year ? 29 : 28;
         end
         4, 6, 9, 11: begin
            return 30;
         end
         default: begin
            return 31;
         end
      endcase
   endfunction

   function automatic void clamp_to_month();
      int limit;
      limit = month_length(nav_year, nav_month);
      if (nav_day > limit) nav_day = limit;
   endfunction

   // Applies one command to the model date and returns the date it reports.
   function automatic date_result_type navigate_date(input logic [3:0] op,
                                                     input logic [13:0] ty,
                                                     input logic [3:0] tm,
                                                     input logic [4:0] td);
      date_result_type outcome;
      int              dim;
      dim = month_length(nav_year, nav_month);
      outcome = '0;
      if (nav_enabled && op <= OP_TODAY) begin
         outcome.handled = 1'b1;
         case (op)
            OP_WEEK_UP: begin
               nav_day = (nav_day > 8) ? nav_day - 7 : 1;
            end
            OP_WEEK_DOWN: begin
               nav_day = nav_day + 7;
               if (nav_day > dim) nav_day = dim;
            end
            OP_DAY_LEFT: begin
               if (nav_day > 1) begin
                  nav_day = nav_day - 1;
               end else if (nav_month > 1) begin
                  nav_month = nav_month - 1;
                  nav_day = month_length(nav_year, nav_month);
               end else if (nav_year > 0) begin
                  nav_year = nav_year - 1;
                  nav_month = 12;
                  nav_day = 31;
               end
            end
            OP_DAY_RIGHT: begin
               if (nav_day < dim) begin
                  nav_day = nav_day + 1;
               end else if (nav_month < 12) begin
                  nav_month = nav_month + 1;
                  nav_day = 1;
               end else if (nav_year < int'(YEAR_MAX)) begin
                  nav_year = nav_year + 1;
                  nav_month = 1;
                  nav_day = 1;
               end
            end
            OP_PREV_MONTH: begin
               if (nav_month > 1) begin
                  nav_month = nav_month - 1;
                  clamp_to_month();
               end else if (nav_year > 0) begin
                  nav_year = nav_year - 1;
                  nav_month = 12;
                  clamp_to_month();
               end
            end
            OP_NEXT_MONTH: begin
               if (nav_month < 12) begin
                  nav_month = nav_month + 1;
                  clamp_to_month();
               end else if (nav_year < int'(YEAR_MAX)) begin
                  nav_year = nav_year + 1;
                  nav_month = 1;
                  clamp_to_month();
               end
            end
            OP_PREV_YEAR: begin
               if (nav_year > 0) begin
                  nav_year = nav_year - 1;
                  if (nav_month == 2) clamp_to_month();
               end
            end
            OP_NEXT_YEAR: begin
               if (nav_year < int'(YEAR_MAX)) begin
                  nav_year = nav_year + 1;
                  if (nav_month == 2) clamp_to_month();
               end
            end
            OP_SELECT: begin
               outcome.selected = 1'b1;
            end
            OP_TODAY: begin
               nav_year = (ty > YEAR_MAX) ? int'(YEAR_MAX) : int'(ty);
               nav_month = (tm < 4'd1) ? 1 : ((tm > 4'd12) ? 12 : int'(tm));
               nav_day = (td < 5'd1) ? 1 : int'(td);
               clamp_to_month();
            end
            default: begin
            end
         endcase
      end
      outcome.year = nav_year[13:0];
      outcome.month = nav_month[3:0];
      outcome.day = nav_day[4:0];
      return outcome;
   endfunction

   task automatic send_command(input logic [3:0] op, input logic [13:0] ty,
                               input logic [3:0] tm, input logic [4:0] td,
                               input logic typed, input date_result_type typed_result);
      date_result_type predicted;
      int              gap;
      if (!steady_run && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 10);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {5'd0, td, tm, ty, op};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predicted = navigate_date(op, ty, tm, td);
      pending_dates.push_back(typed ? typed_result : predicted);
   endtask

   task automatic send_random();
      logic [3:0]  op;
      logic [13:0] ty;
      logic [3:0]  tm;
      logic [4:0]  td;
      op = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(OP_OTHER, OP_TOP_CODE))
                                        : 4'($urandom_range(OP_WEEK_UP, OP_TODAY));
      // Years are drawn near both ends and on century boundaries often enough
      // that the rollover clamps and the leap exceptions come up.
      case ($urandom_range(0, 7))
         0: begin
            ty = 14'($urandom_range(0, 2));
         end
         1: begin
            ty = 14'($urandom_range(9997, 9999));
         end
         2: begin
            ty = 14'($urandom_range(0, 16383));
         end
         3: begin
            ty = 14'($urandom_range(0, 99) * 100);
         end
         default: begin
            ty = 14'($urandom_range(0, 9999));
         end
      endcase
      tm = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(0, 15)) : 4'($urandom_range(1, 12));
      td = ($urandom_range(0, 3) == 0) ? 5'($urandom_range(28, 31)) : 5'($urandom_range(0, 31));
      send_command(op, ty, tm, td, 1'b0, '0);
   endtask

   task automatic wait_idle();
      while (pending_dates.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic write_enable(input logic value);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      nav_enabled = value;
   endtask

   task automatic check_result(input logic [31:0] raw);
      date_result_type got;
      date_result_type want;
      got = '{raw[0], raw[1], raw[15:2], raw[19:16], raw[24:20]};
      result_count++;
      if (pending_dates.size() == 0) begin
         mismatch_count++;
         if (mismatch_count <= 10) begin
            $display("unexpected result transaction %0d: %0d-%0d-%0d", result_count,
                     got.year, got.month, got.day);
         end
      end else begin
         want = pending_dates.pop_front();
         if (got !== want) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
               $display("result %0d: expected h=%0d s=%0d %0d-%0d-%0d, got h=%0d s=%0d %0d-%0d-%0d",
                        result_count, want.handled, want.selected, want.year, want.month,
                        want.day, got.handled, got.selected, got.year, got.month, got.day);
            end
         end
      end
   endtask

   // Receiver: random stalls, plus one long hold that lets the command queue
   // fill up and push back on the sender.
   initial begin
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) check_result(rsp_tdata);
         if (!long_hold_done && result_count >= 100) begin
            long_hold_done = 1'b1;
            stall_left = 300;
         end else if (steady_run) begin
            stall_left = 0;
         end else if (stall_left == 0 && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 10);
         end
         if (stall_left != 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      nav_year = 2000;
      nav_month = 1;
      nav_day = 1;
      nav_enabled = 1'b1;
      write_enable(1'b1);
      foreach (date_script[i]) begin
         send_command(date_script[i].op, date_script[i].today_year,
                      date_script[i].today_month, date_script[i].today_day,
                      date_script[i].typed, date_script[i].result);
      end
      req_tvalid <= 1'b0;
      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         wait_idle();
         write_enable(phase_enable[phase]);
         steady_run = (phase == NUM_PHASES - 1);
         repeat (phase_items[phase]) send_random();
         req_tvalid <= 1'b0;
      end
      while (pending_dates.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("calendar_date_navigator_unit: match");
      end else begin
         $display("calendar_date_navigator_unit: mismatch");
      end
      $finish;
   end

endmodule
